// ===== hdl/ccl_pkg.sv =====
// Shared types, constants and helpers of the connected component labeller.
// Used by ccl_label_store, connected_component_labeller and ccl_checker.
// Depends on nothing.
package ccl_pkg;

   // Frame and label geometry.
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int LABEL_BITS  = 16;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int CNT_BITS    = ADDR_BITS + 1;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT) + 1;

   // Register field widths.
   localparam int GRAY_BITS = 8;
   localparam int SIZE_BITS = 9;
   localparam int CSR_BITS  = 9;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [LABEL_BITS-1:0] LABEL_MAX  = {LABEL_BITS{1'b1}};
   localparam logic [ROW_BITS-1:0]   ROW_SAT    = ROW_BITS'(MAX_HEIGHT);
   localparam logic [SIZE_BITS-1:0]  WIDTH_MAX  = SIZE_BITS'(MAX_WIDTH);
   localparam logic [SIZE_BITS-1:0]  HEIGHT_MAX = SIZE_BITS'(MAX_HEIGHT);

   // Reset values of the configuration registers.
   localparam logic [GRAY_BITS-1:0] THRESHOLD_RESET = GRAY_BITS'(110);
   localparam logic [SIZE_BITS-1:0] WIDTH_RESET     = SIZE_BITS'(256);
   localparam logic [SIZE_BITS-1:0] HEIGHT_RESET    = SIZE_BITS'(256);

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   // Request kinds.
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_LEFT,
      ST_UP,
      ST_DECIDE,
      ST_WALK,
      ST_READ,
      ST_READ_WAIT,
      ST_RESP
   } ccl_state_type;

   // Commands from the sequencer to the label store.
   typedef struct packed {
      logic [ADDR_BITS-1:0]  rd_addr;
      logic                  wr_en;
      logic [ADDR_BITS-1:0]  wr_addr;
      logic [LABEL_BITS-1:0] wr_data;
      logic                  walk_start;
      logic [LABEL_BITS-1:0] walk_from;
      logic [LABEL_BITS-1:0] walk_to;
      logic [ADDR_BITS-1:0]  walk_count;
   } ccl_store_cmd_type;

   // Status back from the label store.
   typedef struct packed {
      logic [LABEL_BITS-1:0] rd_data;
      logic                  walk_busy;
   } ccl_store_sts_type;

   // Size registers below one act as one, above the maximum as the maximum.
   function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                       input logic [SIZE_BITS-1:0] maxv);
      logic [SIZE_BITS-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_BITS'(1);
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

endpackage

// ===== hdl/ccl_label_store.sv =====
// Label memory of the labeller together with the relabel walk engine.
// Depends on ccl_pkg for the command and status structs and the widths.
module ccl_label_store
   import ccl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ccl_store_cmd_type cmd,
   output ccl_store_sts_type sts
);

   logic [LABEL_BITS-1:0] mem [STORE_DEPTH];

   logic                  issue_ff, issue_in;
   logic                  pend_ff, pend_in;
   logic [ADDR_BITS-1:0]  ptr_ff, ptr_in;
   logic [ADDR_BITS-1:0]  last_ff, last_in;
   logic [ADDR_BITS-1:0]  pend_addr_ff, pend_addr_in;
   logic [LABEL_BITS-1:0] from_ff, from_in;
   logic [LABEL_BITS-1:0] to_ff, to_in;
   logic [LABEL_BITS-1:0] rd_data_ff;

   logic [ADDR_BITS-1:0]  rd_addr;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [LABEL_BITS-1:0] wr_data;

   // Walk sequencing: one read issued per cycle, the compare and write-back
   // of that entry follow in the next cycle, when its data comes out.
   always_comb begin
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      ptr_in       = ptr_ff;
      last_in      = last_ff;
      pend_addr_in = pend_addr_ff;
      from_in      = from_ff;
      to_in        = to_ff;
      if (cmd.walk_start && (cmd.walk_count != '0)) begin
         issue_in = 1'b1;
         ptr_in   = '0;
         last_in  = cmd.walk_count - ADDR_BITS'(1);
         from_in  = cmd.walk_from;
         to_in    = cmd.walk_to;
      end else if (issue_ff) begin
         pend_in      = 1'b1;
         pend_addr_in = ptr_ff;
         if (ptr_ff == last_ff) begin
            issue_in = 1'b0;
         end else begin
            ptr_in = ptr_ff + ADDR_BITS'(1);
         end
      end
   end

   // Port arbitration: the walk owns the memory while it runs.
   always_comb begin
      rd_addr = issue_ff ? ptr_ff : cmd.rd_addr;
      if (pend_ff) begin
         wr_en   = (rd_data_ff == from_ff);
         wr_addr = pend_addr_ff;
         wr_data = to_ff;
      end else begin
         wr_en   = cmd.wr_en;
         wr_addr = cmd.wr_addr;
         wr_data = cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      last_ff      <= last_in;
      pend_addr_ff <= pend_addr_in;
      from_ff      <= from_in;
      to_ff        <= to_in;
   end

   // Memory write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Memory read port with registered data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign sts.rd_data   = rd_data_ff;
   assign sts.walk_busy = issue_ff | pend_ff;

endmodule

// ===== hdl/connected_component_labeller.sv =====
// Top level of the streaming connected component labeller.
// Depends on ccl_pkg and instantiates ccl_label_store.
//
// Pixels are loaded in raster order and each load returns the label given to
// the pixel, with 4-connectivity: for a pixel above the threshold the upper
// neighbor's label wins, else the left one's, else a new label opens. A read
// request returns the stored label at a raster position, or 0 if the position
// is not yet written in this frame. The block takes one request at a time and
// holds req_stall high from the transfer until its result has been taken. A
// read passes ST_READ and ST_READ_WAIT before its result, a load ST_LOAD,
// ST_LEFT, ST_UP and ST_DECIDE (a load outside the frame only ST_LOAD); these
// steps follow from the single read port of the label memory, which the
// neighbor fetches use in turn. When a pixel joins two regions with different
// labels, the block walks every entry written before it in this frame, up to
// 65535 of them, one entry per cycle through that same port. Results are held
// in an output register until rsp_stall is low. The label memory needs no
// clearing pass after reset.
module connected_component_labeller
   import ccl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // Request channel.
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_type,
   input  logic [GRAY_BITS-1:0]    req_gray_pixel,
   input  logic                    req_frame_start,
   input  logic [ADDR_BITS-1:0]    req_read_index,
   // Response channel.
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [LABEL_BITS-1:0]   rsp_label,
   output logic                    rsp_is_foreground,
   output logic [LABEL_BITS-1:0]   rsp_labels_opened,
   // Configuration port.
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_write_data
);

   ccl_state_type state_ff, state_in;

   logic [GRAY_BITS-1:0]  threshold_ff;
   logic [SIZE_BITS-1:0]  width_ff;
   logic [SIZE_BITS-1:0]  height_ff;

   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [CNT_BITS-1:0]   pw_ff, pw_in;
   logic [LABEL_BITS-1:0] nl_ff, nl_in;

   logic [GRAY_BITS-1:0]  gray_ff, gray_in;
   logic                  fs_ff, fs_in;
   logic [ADDR_BITS-1:0]  ridx_ff, ridx_in;
   logic [LABEL_BITS-1:0] left_ff, left_in;
   logic [LABEL_BITS-1:0] up_ff, up_in;
   logic [LABEL_BITS-1:0] label_ff, label_in;
   logic                  fg_ff, fg_in;
   logic [LABEL_BITS-1:0] opened_ff, opened_in;

   logic [SIZE_BITS-1:0]  w_eff;
   logic [SIZE_BITS-1:0]  h_eff;

   // Scratch values of the sequencer.
   logic [COL_BITS-1:0]   col_a;
   logic [ROW_BITS-1:0]   row_a;
   logic [CNT_BITS-1:0]   pw_a;
   logic [LABEL_BITS-1:0] nl_a;
   logic [SIZE_BITS-1:0]  col_inc;
   logic [LABEL_BITS-1:0] lab;
   logic                  merge;

   ccl_store_cmd_type store_cmd;
   ccl_store_sts_type store_sts;

   ccl_label_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (store_cmd),
      .sts   (store_sts)
   );

   assign w_eff = clamp_size(width_ff, WIDTH_MAX);
   assign h_eff = clamp_size(height_ff, HEIGHT_MAX);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_THRESHOLD:    threshold_ff <= csr_write_data[GRAY_BITS-1:0];
            CSR_IMAGE_WIDTH:  width_ff     <= csr_write_data[SIZE_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff    <= csr_write_data[SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: next state, datapath updates and store commands.
   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      pw_in     = pw_ff;
      nl_in     = nl_ff;
      gray_in   = gray_ff;
      fs_in     = fs_ff;
      ridx_in   = ridx_ff;
      left_in   = left_ff;
      up_in     = up_ff;
      label_in  = label_ff;
      fg_in     = fg_ff;
      opened_in = opened_ff;

      col_a   = fs_ff ? '0 : col_ff;
      row_a   = fs_ff ? '0 : row_ff;
      pw_a    = fs_ff ? '0 : pw_ff;
      nl_a    = fs_ff ? '0 : nl_ff;
      col_inc = SIZE_BITS'(col_ff) + SIZE_BITS'(1);
      lab     = '0;
      merge   = 1'b0;

      store_cmd            = '0;
      store_cmd.wr_addr    = pw_ff[ADDR_BITS-1:0];
      store_cmd.walk_from  = left_ff;
      store_cmd.walk_to    = up_ff;
      store_cmd.walk_count = pw_ff[ADDR_BITS-1:0];

      req_stall = 1'b1;
      rsp_valid = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               gray_in  = req_gray_pixel;
               fs_in    = req_frame_start;
               ridx_in  = req_read_index;
               state_in = (req_type == REQ_READ) ? ST_READ : ST_LOAD;
            end
         end

         // Frame restart and a pending row wrap, then fetch the left neighbor, or answer 0 outside the frame.
         ST_LOAD: begin
            if (SIZE_BITS'(col_a) >= w_eff) begin
               col_a = '0;
               if (row_a != ROW_SAT) begin
                  row_a = row_a + ROW_BITS'(1);
               end
            end
            col_in = col_a;
            row_in = row_a;
            pw_in  = pw_a;
            nl_in  = nl_a;
            store_cmd.rd_addr = pw_a[ADDR_BITS-1:0] - ADDR_BITS'(1);
            if ((row_a >= ROW_BITS'(h_eff)) || (pw_a >= CNT_BITS'(STORE_DEPTH))) begin
               label_in  = '0;
               fg_in     = 1'b0;
               opened_in = nl_a;
               state_in  = ST_RESP;
            end else begin
               state_in = ST_LEFT;
            end
         end

         // Left data arrives; fetch the upper neighbor.
         ST_LEFT: begin
            left_in = ((col_ff != '0) && (pw_ff != '0)) ? store_sts.rd_data : '0;
            store_cmd.rd_addr = pw_ff[ADDR_BITS-1:0] - ADDR_BITS'(w_eff);
            state_in = ST_UP;
         end

         ST_UP: begin
            up_in = ((row_ff != '0) && (pw_ff >= CNT_BITS'(w_eff))) ?
                    store_sts.rd_data : '0;
            state_in = ST_DECIDE;
         end

         // Pick the label, store it, advance the raster position and start a walk on a merge.
         ST_DECIDE: begin
            if (gray_ff > threshold_ff) begin
               if (up_ff != '0) begin
                  lab   = up_ff;
                  merge = (left_ff != '0) && (left_ff != up_ff);
               end else if (left_ff != '0) begin
                  lab = left_ff;
               end else begin
                  if (nl_ff != LABEL_MAX) begin
                     nl_in = nl_ff + LABEL_BITS'(1);
                  end
                  lab = nl_in;
               end
            end
            store_cmd.wr_en      = 1'b1;
            store_cmd.wr_data    = lab;
            store_cmd.walk_start = merge;
            pw_in = pw_ff + CNT_BITS'(1);
            if (col_inc >= w_eff) begin
               col_in = '0;
               if (row_ff != ROW_SAT) begin
                  row_in = row_ff + ROW_BITS'(1);
               end
            end else begin
               col_in = col_inc[COL_BITS-1:0];
            end
            label_in  = lab;
            fg_in     = (lab != '0);
            opened_in = nl_in;
            state_in  = merge ? ST_WALK : ST_RESP;
         end

         ST_WALK: begin
            if (!store_sts.walk_busy) begin
               state_in = ST_RESP;
            end
         end

         ST_READ: begin
            store_cmd.rd_addr = ridx_ff;
            state_in = ST_READ_WAIT;
         end

         ST_READ_WAIT: begin
            label_in  = (CNT_BITS'(ridx_ff) < pw_ff) ? store_sts.rd_data : '0;
            fg_in     = (label_in != '0);
            opened_in = nl_ff;
            state_in  = ST_RESP;
         end

         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         pw_ff    <= '0;
         nl_ff    <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         pw_ff    <= pw_in;
         nl_ff    <= nl_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      gray_ff   <= gray_in;
      fs_ff     <= fs_in;
      ridx_ff   <= ridx_in;
      left_ff   <= left_in;
      up_ff     <= up_in;
      label_ff  <= label_in;
      fg_ff     <= fg_in;
      opened_ff <= opened_in;
   end

   assign rsp_label         = label_ff;
   assign rsp_is_foreground = fg_ff;
   assign rsp_labels_opened = opened_ff;

endmodule

// ===== hdl/ccl_checker.sv =====
// Port-level checks of the connected component labeller, and the bind
// that attaches them to the top level. Depends on ccl_pkg.
module ccl_checker
   import ccl_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [LABEL_BITS-1:0]   rsp_label,
   input logic                    rsp_is_foreground,
   input logic [LABEL_BITS-1:0]   rsp_labels_opened
);

   // The foreground flag always agrees with the label it comes with.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_foreground == (rsp_label != '0)))
      else $error("foreground flag disagrees with label");

   // No new request is taken while a result waits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   // A request transfer closes the input side on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request accepted back to back");

   // A result leaves after its transfer and is not repeated.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result repeated after transfer");

   // A stalled result holds its label and label count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_label)
                                    && $stable(rsp_labels_opened)))
      else $error("stalled result changed");

endmodule

bind connected_component_labeller ccl_checker u_ccl_checker (.*);

// ===== sim/connected_component_labeller_test.sv =====
// Self-checking testbench for the connected component labeller.
// Predicts every label, read-back and label count on its own; depends on ccl_pkg and the RTL.
// Random valid/stall pacing on both channels, with one long receiver hold-off.
module connected_component_labeller_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ccl_pkg::*;

   // One result as the block should return it.
   typedef struct packed {
      logic [LABEL_BITS-1:0] label;
      logic                  is_foreground;
      logic [LABEL_BITS-1:0] labels_opened;
   } label_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_type = REQ_LOAD;
   logic [GRAY_BITS-1:0]    req_gray_pixel = '0;
   logic                    req_frame_start = 1'b0;
   logic [ADDR_BITS-1:0]    req_read_index = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [LABEL_BITS-1:0]   rsp_label;
   logic                    rsp_is_foreground;
   logic [LABEL_BITS-1:0]   rsp_labels_opened;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_THRESHOLD;
   logic [CSR_BITS-1:0]     csr_write_data = '0;

   // Predicted block state and configuration.
   logic [LABEL_BITS-1:0] label_copy [STORE_DEPTH];
   logic [GRAY_BITS-1:0]  cfg_threshold = THRESHOLD_RESET;
   logic [SIZE_BITS-1:0]  cfg_width = WIDTH_RESET;
   logic [SIZE_BITS-1:0]  cfg_height = HEIGHT_RESET;
   int unsigned           col_pos = 0;
   int unsigned           row_pos = 0;
   int unsigned           written_count = 0;
   int unsigned           opened_count = 0;

   label_result_type pending_labels [$];
   int unsigned   mismatch_count = 0;
   bit            req_held = 1'b0;
   bit            no_gaps = 1'b0;
   int unsigned   hold_off_request = 0;

   connected_component_labeller u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_gray_pixel    (req_gray_pixel),
      .req_frame_start   (req_frame_start),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_label         (rsp_label),
      .rsp_is_foreground (rsp_is_foreground),
      .rsp_labels_opened (rsp_labels_opened),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #4 clock = ~clock;

   // Size register as the block uses it: zero acts as one, large values saturate.
   function automatic int unsigned eff_size(logic [SIZE_BITS-1:0] v, int unsigned maxv);
      if (v == '0) return 1;
      if (v > maxv) return maxv;
      return 32'(v);
   endfunction

   // True when the next load without frame start falls outside the frame.
   function automatic bit frame_full();
      int unsigned w;
      int unsigned h;
      w = eff_size(cfg_width, MAX_WIDTH);
      h = eff_size(cfg_height, MAX_HEIGHT);
      return (((col_pos >= w) ? row_pos + 1 : row_pos) >= h) || written_count >= STORE_DEPTH;
   endfunction

   // Labels one request and advances the predicted state.
   function automatic label_result_type predict_label(logic kind, logic [GRAY_BITS-1:0] gray,
                                                      logic fs, logic [ADDR_BITS-1:0] ridx);
      int unsigned           w;
      int unsigned           h;
      int unsigned           idx;
      logic [LABEL_BITS-1:0] left_lab;
      logic [LABEL_BITS-1:0] up_lab;
      logic [LABEL_BITS-1:0] lab;
      label_result_type      res;
      w = eff_size(cfg_width, MAX_WIDTH);
      h = eff_size(cfg_height, MAX_HEIGHT);
      lab = '0;
      if (kind == REQ_READ) begin
         if (ridx < written_count) lab = label_copy[ridx];
      end else begin
         if (fs) begin
            col_pos = 0;
            row_pos = 0;
            written_count = 0;
            opened_count = 0;
         end
         // A narrowed width wraps the column before the pixel is placed.
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         idx = written_count;
         if (row_pos < h && idx < STORE_DEPTH) begin
            left_lab = '0;
            up_lab = '0;
            if (col_pos > 0 && idx >= 1) left_lab = label_copy[idx - 1];
            if (row_pos > 0 && idx >= w) up_lab = label_copy[idx - w];
            if (gray > cfg_threshold) begin
               if (up_lab != '0) begin
                  lab = up_lab;
                  // Two regions meet: fold the left label into the upper one.
                  if (left_lab != '0 && left_lab != up_lab) begin
                     for (int unsigned i = 0; i < idx; i++) begin
                        if (label_copy[i] == left_lab) label_copy[i] = up_lab;
                     end
                  end
               end else if (left_lab != '0) begin
                  lab = left_lab;
               end else begin
                  if (opened_count < LABEL_MAX) opened_count++;
                  lab = LABEL_BITS'(opened_count);
               end
            end
            label_copy[idx] = lab;
            written_count = idx + 1;
            col_pos++;
            if (col_pos >= w) begin
               col_pos = 0;
               row_pos++;
            end
         end
      end
      res.label = lab;
      res.is_foreground = (lab != '0);
      res.labels_opened = LABEL_BITS'(opened_count);
      return res;
   endfunction

   // Offers one request and records its expected result once the transfer happens.
   task automatic send_item(input logic kind, input logic [GRAY_BITS-1:0] gray,
                            input logic fs, input logic [ADDR_BITS-1:0] ridx);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         if (req_held) begin
            req_valid <= 1'b0;
            req_held = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_gray_pixel <= gray;
      req_frame_start <= fs;
      req_read_index <= ridx;
      do @(posedge clock); while (req_stall !== 1'b0);
      req_held = 1'b1;
      pending_labels.push_back(predict_label(kind, gray, fs, ridx));
   endtask

   // Lowers the request and waits for every outstanding result.
   task automatic drain_results();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
      while (pending_labels.size() != 0) @(posedge clock);
   endtask

   // Register write; only called while the block is idle.
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] reg_index,
                            input logic [CSR_BITS-1:0] reg_value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= reg_index;
      csr_write_data <= reg_value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (reg_index)
         CSR_THRESHOLD:    cfg_threshold = reg_value[GRAY_BITS-1:0];
         CSR_IMAGE_WIDTH:  cfg_width = reg_value;
         CSR_IMAGE_HEIGHT: cfg_height = reg_value;
         default: ;
      endcase
   endtask

   // Reset configuration: threshold boundary, new label, reads incl. unwritten ones.
   task automatic test_reset_values();
      send_item(REQ_LOAD, 8'd110, 1'b1, '0);
      send_item(REQ_LOAD, 8'd111, 1'b0, '0);
      send_item(REQ_LOAD, 8'd255, 1'b0, '0);
      send_item(REQ_READ, 8'd0, 1'b0, 16'd1);
      send_item(REQ_READ, 8'd0, 1'b1, 16'd0);
      send_item(REQ_READ, 8'd0, 1'b0, 16'hFFFF);
   endtask

   // U-shaped region whose arms join, forcing a relabel walk, then a load past the frame.
   task automatic test_merge_walk();
      logic [GRAY_BITS-1:0] pattern [12] = '{8'd255, 8'd0, 8'd255, 8'd0,
                                             8'd1,   8'd1, 8'd1,   8'd0,
                                             8'd0,   8'd0, 8'd0,   8'd0};
      drain_results();
      write_reg(CSR_THRESHOLD, 9'd0);
      write_reg(CSR_IMAGE_WIDTH, 9'd4);
      write_reg(CSR_IMAGE_HEIGHT, 9'd3);
      foreach (pattern[i]) send_item(REQ_LOAD, pattern[i], i == 0, '0);
      send_item(REQ_LOAD, 8'd255, 1'b0, '0);
      send_item(REQ_READ, 8'd0, 1'b0, 16'd0);
      send_item(REQ_READ, 8'd0, 1'b0, 16'd4);
      send_item(REQ_READ, 8'd0, 1'b0, 16'd5);
      send_item(REQ_READ, 8'd0, 1'b0, 16'd12);
   endtask

   // Size registers at zero and above the maximum, and width changes mid-frame.
   task automatic test_size_limits();
      drain_results();
      write_reg(CSR_IMAGE_WIDTH, 9'd0);
      write_reg(CSR_IMAGE_HEIGHT, 9'd0);
      send_item(REQ_LOAD, 8'd200, 1'b1, '0);
      send_item(REQ_LOAD, 8'd200, 1'b0, '0);
      drain_results();
      write_reg(CSR_IMAGE_WIDTH, 9'd511);
      write_reg(CSR_IMAGE_HEIGHT, 9'd511);
      send_item(REQ_LOAD, 8'd200, 1'b0, '0);
      drain_results();
      write_reg(CSR_IMAGE_WIDTH, 9'd1);
      send_item(REQ_LOAD, 8'd200, 1'b0, '0);
   endtask

   // The receiver holds off for a long stretch while loads keep coming back to back.
   task automatic test_backpressure();
      drain_results();
      write_reg(CSR_THRESHOLD, 9'd128);
      write_reg(CSR_IMAGE_WIDTH, 9'd8);
      write_reg(CSR_IMAGE_HEIGHT, 9'd4);
      no_gaps = 1'b1;
      hold_off_request = 200;
      for (int i = 0; i < 8; i++) begin
         send_item(REQ_LOAD, GRAY_BITS'($urandom_range(0, 255)), i == 0, '0);
      end
      no_gaps = 1'b0;
   endtask

   // Random frames under several settings, mostly loads with some reads mixed in.
   task automatic test_random_frames();
      int unsigned          shape;
      int unsigned          counted;
      logic                 fs;
      logic [GRAY_BITS-1:0] gray;
      logic [SIZE_BITS-1:0] w_reg;
      logic [SIZE_BITS-1:0] h_reg;
      logic [ADDR_BITS-1:0] ridx;
      for (int phase = 0; phase < 7; phase++) begin
         drain_results();
         shape = (phase < 2) ? phase : $urandom_range(2, 5);
         case (shape)
            0: begin
               w_reg = $urandom_range(0, 1) ? 9'd256 : 9'd511;
               h_reg = SIZE_BITS'($urandom_range(0, 2));
            end
            1: begin
               w_reg = SIZE_BITS'($urandom_range(0, 1));
               h_reg = $urandom_range(0, 1) ? 9'd256 : 9'd511;
            end
            default: begin
               w_reg = SIZE_BITS'($urandom_range(2, 12));
               h_reg = SIZE_BITS'($urandom_range(1, 8));
            end
         endcase
         write_reg(CSR_THRESHOLD, (phase == 0) ? 9'd0 : (phase == 1) ? 9'd255 :
                   CSR_BITS'($urandom_range(0, 255)));
         write_reg(CSR_IMAGE_WIDTH, w_reg);
         write_reg(CSR_IMAGE_HEIGHT, h_reg);
         no_gaps = (phase == 3);
         counted = 0;
         while (counted < 10) begin
            if ($urandom_range(0, 99) < 20) begin
               // Reads mostly land on written positions, sometimes anywhere.
               ridx = ($urandom_range(0, 3) == 0) ? ADDR_BITS'($urandom_range(0, 65535)) :
                      ADDR_BITS'($urandom_range(0, written_count));
               send_item(REQ_READ, GRAY_BITS'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), ridx);
               counted++;
            end else begin
               fs = frame_full() ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0);
               if (cfg_threshold != 8'hFF && $urandom_range(0, 9) < 6) begin
                  gray = GRAY_BITS'($urandom_range(int'(cfg_threshold) + 1, 255));
               end else begin
                  gray = GRAY_BITS'($urandom_range(0, 255));
               end
               if (fs || !frame_full()) counted++;
               send_item(REQ_LOAD, gray, fs, ADDR_BITS'($urandom_range(0, 65535)));
            end
         end
      end
      no_gaps = 1'b0;
   endtask

   // Receiver pacing: a random stall before each result, or a requested long hold-off.
   initial begin : response_pacing
      int unsigned stall_cycles;
      wait (reset == 1'b0);
      forever begin
         if (hold_off_request != 0) begin
            stall_cycles = hold_off_request;
            hold_off_request = 0;
         end else begin
            stall_cycles = no_gaps ? 0 : $urandom_range(0, 7);
         end
         if (stall_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Compare each result transfer against the oldest expectation.
   always @(posedge clock) begin : result_check
      label_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_labels.size() == 0) begin
            $display("%0t: result with none expected: label %0d fg %0d opened %0d",
                     $time, rsp_label, rsp_is_foreground, rsp_labels_opened);
            mismatch_count++;
         end else begin
            want = pending_labels.pop_front();
            if (want.label !== rsp_label || want.is_foreground !== rsp_is_foreground ||
                want.labels_opened !== rsp_labels_opened) begin
               $display("%0t: expected label %0d fg %0d opened %0d, got %0d fg %0d opened %0d",
                        $time, want.label, want.is_foreground, want.labels_opened,
                        rsp_label, rsp_is_foreground, rsp_labels_opened);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_merge_walk();
      test_size_limits();
      test_backpressure();
      test_random_frames();
      drain_results();
      // Give a stray extra result time to show up.
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[connected_component_labeller] OK");
      end else begin
         $display("[connected_component_labeller] ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #8_000_000;
      $display("[connected_component_labeller] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/ccl_pkg.sv
hdl/ccl_label_store.sv
hdl/connected_component_labeller.sv
hdl/ccl_checker.sv
sim/connected_component_labeller_test.sv
